// ===== sv/coap_message_parser_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the CoAP message parser
// Clocked concurrent checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef COAP_MESSAGE_PARSER_TOP_ASSERT_SVH
`define COAP_MESSAGE_PARSER_TOP_ASSERT_SVH

// check that an expression holds at every edge
`define CMP_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// check that a consequent holds in the cycle after an antecedent
`define CMP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// check that a consequent holds in the same cycle as an antecedent
`define CMP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== sv/cmp_pkg.sv =====
// ----------------------------------------------------------------------------
// CoAP message parser package
// Item types, result codes and size limits shared by the parser ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmp_pkg;

   localparam int MAX_PACKET  = 512;
   localparam int MAX_OPTIONS = 10;
   localparam int IDX_W       = $clog2(MAX_PACKET + 1);
   localparam int MAX_TOKEN   = 8;

   localparam logic [1:0] COAP_VERSION    = 2'd1;
   localparam logic [1:0] TYPE_ACK        = 2'd2;
   localparam logic [7:0] PAYLOAD_MARKER  = 8'hFF;
   localparam logic [3:0] NIBBLE_EXT_BYTE = 4'd13;
   localparam logic [3:0] NIBBLE_EXT_WORD = 4'd14;
   localparam logic [3:0] NIBBLE_RESERVED = 4'd15;

   typedef enum logic [2:0] {
      KIND_HEADER  = 3'd0,
      KIND_TOKEN   = 3'd1,
      KIND_OPTION  = 3'd2,
      KIND_VALUE   = 3'd3,
      KIND_PAYLOAD = 3'd4,
      KIND_END     = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_ACK     = 3'd0,
      ST_SHORT   = 3'd1,
      ST_VERSION = 3'd2,
      ST_TOKEN   = 3'd3,
      ST_OPTION  = 3'd4,
      ST_NOT_ACK = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_datagram;
   } req_type;

   typedef struct packed {
      kind_type   item_kind;
      logic [1:0]  message_type;
      logic [3:0]  token_length;
      logic [7:0]  message_code;
      logic [15:0] message_id;
      logic [15:0] option_number;
      logic [15:0] option_length;
      logic [7:0]  value_byte;
      status_type  status;
      logic        last_of_run;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/coap_message_parser_top.sv =====
// ----------------------------------------------------------------------------
// CoAP message parser
// Decodes a byte stream of CoAP datagrams into header, token, option,
// value, payload and end-of-packet items.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one datagram byte per item, end_of_datagram on the final byte.
//   rsp_*  : decoded items; every byte yields zero, one or two items, and
//            last_of_run marks the final item of a byte.
// Items are registered in the output queue and appear on rsp_* from its head.
// Throughput: one byte per clock while at most one item waits in the
//   three-entry output queue; the output port moves one item per clock while
//   rsp_ready is high. A byte that yields two items (a datagram's last byte)
//   can fill the queue, and req_ready drops once two items are queued.
// Reset: parser returns to header byte zero and the output queue empties.
// Stall: when rsp_ready is low items collect in the queue; req_ready falls
//   with two items queued, so no item is lost or dropped.
// Bytes beyond MAX_PACKET in a datagram are consumed without items, but for the end item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "coap_message_parser_top_assert.svh"

module coap_message_parser_top
   import cmp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   typedef enum logic [3:0] {
      PH_H0      = 4'd0,
      PH_H1      = 4'd1,
      PH_H2      = 4'd2,
      PH_H3      = 4'd3,
      PH_TOKEN   = 4'd4,
      PH_OPT     = 4'd5,
      PH_D13     = 4'd6,
      PH_D14H    = 4'd7,
      PH_D14L    = 4'd8,
      PH_L13     = 4'd9,
      PH_L14H    = 4'd10,
      PH_L14L    = 4'd11,
      PH_VALUE   = 4'd12,
      PH_PAYLOAD = 4'd13,
      PH_DISCARD = 4'd14
   } phase_type;

   typedef struct packed {
      logic [1:0]  msg_type;
      logic [3:0]  tkl;
      logic [7:0]  code;
      logic [15:0] id;
   } hdr_type;

   function automatic rsp_type mk_rsp(kind_type k, hdr_type h, logic [15:0] num,
                                      logic [15:0] len, logic [7:0] v, status_type s);
      rsp_type r;
      r.item_kind     = k;
      r.message_type  = h.msg_type;
      r.token_length  = h.tkl;
      r.message_code  = h.code;
      r.message_id    = h.id;
      r.option_number = num;
      r.option_length = len;
      r.value_byte    = v;
      r.status        = s;
      r.last_of_run   = 1'b0;
      return r;
   endfunction

   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   hdr_type          hdr_ff, hdr_in;
   status_type       err_ff, err_in;
   logic [3:0]       tok_ff, tok_in;
   logic [15:0]      num_ff, num_in;
   logic [15:0]      dlt_ff, dlt_in;
   logic [15:0]      vlen_ff, vlen_in;
   logic [3:0]       opts_ff, opts_in;

   rsp_type          q_ff [3];
   rsp_type          q_in [3];
   logic [1:0]       cnt_ff, cnt_in;

   rsp_type          res0, res1, fin;
   logic [1:0]       n_res;
   logic             acc;

   assign acc       = req_valid && req_ready;
   assign req_ready = (cnt_ff <= 2'd1);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = q_ff[0];

   // parse one byte
   always_comb begin
      logic [7:0] b;
      logic       delta_fin;
      logic       open_opt;
      status_type st;
      b         = req_data.data_byte;
      delta_fin = 1'b0;
      open_opt  = 1'b0;
      st        = ST_ACK;
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      hdr_in    = hdr_ff;
      err_in    = err_ff;
      tok_in    = tok_ff;
      num_in    = num_ff;
      dlt_in    = dlt_ff;
      vlen_in   = vlen_ff;
      opts_in   = opts_ff;
      n_res     = 2'd0;
      res0      = '0;
      res1      = '0;
      fin       = '0;
      if (idx_ff < IDX_W'(MAX_PACKET)) begin
         idx_in = idx_ff + IDX_W'(1);
         unique case (phase_ff)
            PH_H0: begin
               hdr_in   = '{msg_type: b[5:4], tkl: b[3:0], code: 8'd0, id: 16'd0};
               err_in   = (b[7:6] != COAP_VERSION) ? ST_VERSION : ST_ACK;
               phase_in = PH_H1;
            end
            PH_H1: begin
               hdr_in.code = b;
               phase_in    = PH_H2;
            end
            PH_H2: begin
               hdr_in.id[15:8] = b;
               phase_in        = PH_H3;
            end
            PH_H3: begin
               hdr_in.id[7:0] = b;
               res0  = mk_rsp(KIND_HEADER, hdr_in, 16'd0, 16'd0, 8'd0, ST_ACK);
               n_res = 2'd1;
               if (err_ff != ST_ACK) begin
                  phase_in = PH_DISCARD;
               end else if (hdr_in.tkl > 4'(MAX_TOKEN)) begin
                  err_in   = ST_TOKEN;
                  phase_in = PH_DISCARD;
               end else if (hdr_in.tkl == 4'd0) begin
                  phase_in = PH_OPT;
               end else begin
                  tok_in   = hdr_in.tkl;
                  phase_in = PH_TOKEN;
               end
            end
            PH_TOKEN: begin
               res0   = mk_rsp(KIND_TOKEN, hdr_ff, 16'd0, 16'd0, b, ST_ACK);
               n_res  = 2'd1;
               tok_in = tok_ff - 4'd1;
               if (tok_in == 4'd0) begin
                  phase_in = PH_OPT;
               end
            end
            PH_OPT: begin
               if (b == PAYLOAD_MARKER) begin
                  phase_in = PH_PAYLOAD;
               end else if (opts_ff >= 4'(MAX_OPTIONS)) begin
                  phase_in = PH_DISCARD;
               end else if (b[7:4] == NIBBLE_RESERVED || b[3:0] == NIBBLE_RESERVED) begin
                  err_in   = ST_OPTION;
                  phase_in = PH_DISCARD;
               end else begin
                  vlen_in = {12'd0, b[3:0]};
                  if (b[7:4] < NIBBLE_EXT_BYTE) begin
                     dlt_in    = {12'd0, b[7:4]};
                     delta_fin = 1'b1;
                  end else begin
                     phase_in = (b[7:4] == NIBBLE_EXT_BYTE) ? PH_D13 : PH_D14H;
                  end
               end
            end
            PH_D13: begin
               dlt_in    = {8'd0, b} + 16'd13;
               delta_fin = 1'b1;
            end
            PH_D14H: begin
               dlt_in   = {8'd0, b};
               phase_in = PH_D14L;
            end
            PH_D14L: begin
               dlt_in    = {dlt_ff[7:0], b} + 16'd269;
               delta_fin = 1'b1;
            end
            PH_L13: begin
               vlen_in  = {8'd0, b} + 16'd13;
               open_opt = 1'b1;
            end
            PH_L14H: begin
               vlen_in  = {8'd0, b};
               phase_in = PH_L14L;
            end
            PH_L14L: begin
               vlen_in  = {vlen_ff[7:0], b} + 16'd269;
               open_opt = 1'b1;
            end
            PH_VALUE: begin
               res0    = mk_rsp(KIND_VALUE, hdr_ff, num_ff, 16'd0, b, ST_ACK);
               n_res   = 2'd1;
               vlen_in = vlen_ff - 16'd1;
               if (vlen_in == 16'd0) begin
                  phase_in = PH_OPT;
               end
            end
            PH_PAYLOAD: begin
               res0  = mk_rsp(KIND_PAYLOAD, hdr_ff, 16'd0, 16'd0, b, ST_ACK);
               n_res = 2'd1;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         if (delta_fin) begin
            if (vlen_in == 16'(NIBBLE_EXT_BYTE)) begin
               phase_in = PH_L13;
            end else if (vlen_in == 16'(NIBBLE_EXT_WORD)) begin
               phase_in = PH_L14H;
            end else begin
               open_opt = 1'b1;
            end
         end
         if (open_opt) begin
            num_in   = num_ff + dlt_in;
            opts_in  = opts_ff + 4'd1;
            res0     = mk_rsp(KIND_OPTION, hdr_in, num_in, vlen_in, 8'd0, ST_ACK);
            n_res    = 2'd1;
            phase_in = (vlen_in != 16'd0) ? PH_VALUE : PH_OPT;
         end
      end
      if (req_data.end_of_datagram) begin
         priority if (phase_in <= PH_TOKEN) begin
            st = ST_SHORT;
         end else if (phase_in >= PH_D13 && phase_in <= PH_VALUE) begin
            st = ST_OPTION;
         end else if (err_in != ST_ACK) begin
            st = err_in;
         end else begin
            st = (hdr_in.msg_type == TYPE_ACK) ? ST_ACK : ST_NOT_ACK;
         end
         fin = mk_rsp(KIND_END, (phase_in >= PH_TOKEN) ? hdr_in : '0,
                      16'd0, 16'd0, 8'd0, st);
         if (n_res == 2'd0) begin
            res0 = fin;
         end else begin
            res1 = fin;
         end
         n_res    = n_res + 2'd1;
         phase_in = PH_H0;
         idx_in   = '0;
         hdr_in   = '0;
         err_in   = ST_ACK;
         tok_in   = '0;
         num_in   = '0;
         dlt_in   = '0;
         vlen_in  = '0;
         opts_in  = '0;
      end
      if (n_res == 2'd1) begin
         res0.last_of_run = 1'b1;
      end
      if (n_res == 2'd2) begin
         res1.last_of_run = 1'b1;
      end
   end

   // output queue: shift on pop, append new items behind
   always_comb begin
      logic       pop;
      logic [1:0] base;
      logic [1:0] push;
      rsp_type    sh [3];
      pop   = rsp_valid && rsp_ready;
      push  = acc ? n_res : 2'd0;
      base  = cnt_ff - {1'b0, pop};
      sh[0] = pop ? q_ff[1] : q_ff[0];
      sh[1] = pop ? q_ff[2] : q_ff[1];
      sh[2] = q_ff[2];
      for (int i = 0; i < 3; i++) begin
         q_in[i] = sh[i];
         if (push != 2'd0 && 2'(i) == base) begin
            q_in[i] = res0;
         end else if (push == 2'd2 && 2'(i) == base + 2'd1) begin
            q_in[i] = res1;
         end
      end
      cnt_in = base + push;
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff   <= '0;
         phase_ff <= PH_H0;
         idx_ff   <= '0;
         hdr_ff   <= '0;
         err_ff   <= ST_ACK;
         tok_ff   <= '0;
         num_ff   <= '0;
         dlt_ff   <= '0;
         vlen_ff  <= '0;
         opts_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (acc) begin
            phase_ff <= phase_in;
            idx_ff   <= idx_in;
            hdr_ff   <= hdr_in;
            err_ff   <= err_in;
            tok_ff   <= tok_in;
            num_ff   <= num_in;
            dlt_ff   <= dlt_in;
            vlen_ff  <= vlen_in;
            opts_ff  <= opts_in;
         end
      end
   end

   `CMP_ASSERT_NEXT(a_end_clears, acc && req_data.end_of_datagram,
      phase_ff == PH_H0 && idx_ff == '0, "datagram end did not clear parser")
   `CMP_ASSERT_SAME(a_end_last, rsp_valid && rsp_data.item_kind == KIND_END,
      rsp_data.last_of_run, "packet end item without last_of_run")
   `CMP_ASSERT_ALWAYS(a_idx_bound, idx_ff <= IDX_W'(MAX_PACKET), "byte index overrun")
   `CMP_ASSERT_SAME(a_discard_cause, phase_ff == PH_DISCARD,
      err_ff != ST_ACK || opts_ff >= 4'(MAX_OPTIONS), "discard without cause")

endmodule

`default_nettype wire

// ===== sim/coap_message_parser_check.sv =====
// ----------------------------------------------------------------------------
// CoAP message parser item check
// Watches both channels of the parser and tracks the datagram parse state of
// every accepted byte. Works out the items each byte should produce and
// compares every item that leaves the parser, field by field, against the
// oldest one still owed. Hands the mismatch count and the number of items
// still owed to the test top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module coap_message_parser_check
   import cmp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int           mismatch_count,
   output int           pending_items
);

   localparam logic [15:0] EXT_BYTE_BIAS   = 16'd13;
   localparam logic [15:0] EXT_WORD_BIAS   = 16'd269;

   typedef enum logic [3:0] {
      PH_HDR0,
      PH_HDR1,
      PH_HDR2,
      PH_HDR3,
      PH_TOKEN,
      PH_OPTION,
      PH_DELTA13,
      PH_DELTA14_HI,
      PH_DELTA14_LO,
      PH_LEN13,
      PH_LEN14_HI,
      PH_LEN14_LO,
      PH_VALUE,
      PH_PAYLOAD,
      PH_SKIP
   } phase_type;

   phase_type   phase;
   int unsigned byte_count;
   logic [1:0]  hdr_msg_type;
   logic [3:0]  hdr_tkl;
   logic [7:0]  hdr_code;
   logic [15:0] hdr_id;
   logic [3:0]  token_left;
   logic [15:0] option_number;
   logic [15:0] option_delta;
   logic [15:0] value_left;
   logic [3:0]  option_count;
   status_type  parse_error;   // ST_ACK while no error is pending

   rsp_type byte_items[$];
   rsp_type owed_items[$];

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch, %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   task automatic check_item(input rsp_type got, input rsp_type want);
      check_field("item_kind", got.item_kind, want.item_kind);
      check_field("message_type", got.message_type, want.message_type);
      check_field("token_length", got.token_length, want.token_length);
      check_field("message_code", got.message_code, want.message_code);
      check_field("message_id", got.message_id, want.message_id);
      check_field("option_number", got.option_number, want.option_number);
      check_field("option_length", got.option_length, want.option_length);
      check_field("value_byte", got.value_byte, want.value_byte);
      check_field("status", got.status, want.status);
      check_field("last_of_run", got.last_of_run, want.last_of_run);
   endtask

   function automatic rsp_type make_item(input kind_type kind, input bit with_header,
                                         input logic [15:0] number,
                                         input logic [15:0] length,
                                         input logic [7:0] value, input status_type st);
      rsp_type r;
      r = '0;
      r.item_kind = kind;
      if (with_header) begin
         r.message_type = hdr_msg_type;
         r.token_length = hdr_tkl;
         r.message_code = hdr_code;
         r.message_id   = hdr_id;
      end
      r.option_number = number;
      r.option_length = length;
      r.value_byte    = value;
      r.status        = st;
      return r;
   endfunction

   task automatic add_item(input rsp_type item);
      byte_items = {byte_items, item};
   endtask

   task automatic clear_parser();
      phase         = PH_HDR0;
      byte_count    = 0;
      hdr_msg_type  = '0;
      hdr_tkl       = '0;
      hdr_code      = '0;
      hdr_id        = '0;
      token_left    = '0;
      option_number = '0;
      option_delta  = '0;
      value_left    = '0;
      option_count  = '0;
      parse_error   = ST_ACK;
   endtask

   task automatic open_option();
      option_number = option_number + option_delta;
      option_count  = option_count + 4'd1;
      add_item(make_item(KIND_OPTION, 1'b1, option_number, value_left, '0, ST_ACK));
      phase = (value_left != '0) ? PH_VALUE : PH_OPTION;
   endtask

   task automatic finish_delta();
      if (value_left == 16'(NIBBLE_EXT_BYTE)) begin
         phase = PH_LEN13;
      end else if (value_left == 16'(NIBBLE_EXT_WORD)) begin
         phase = PH_LEN14_HI;
      end else begin
         open_option();
      end
   endtask

   task automatic parse_byte(input logic [7:0] b);
      case (phase)
         PH_HDR0: begin
            hdr_msg_type = b[5:4];
            hdr_tkl      = b[3:0];
            hdr_code     = '0;
            hdr_id       = '0;
            parse_error  = (b[7:6] != COAP_VERSION) ? ST_VERSION : ST_ACK;
            phase        = PH_HDR1;
         end
         PH_HDR1: begin
            hdr_code = b;
            phase    = PH_HDR2;
         end
         PH_HDR2: begin
            hdr_id[15:8] = b;
            phase        = PH_HDR3;
         end
         PH_HDR3: begin
            hdr_id[7:0] = b;
            add_item(make_item(KIND_HEADER, 1'b1, '0, '0, '0, ST_ACK));
            if (parse_error != ST_ACK) begin
               phase = PH_SKIP;
            end else if (hdr_tkl > MAX_TOKEN) begin
               parse_error = ST_TOKEN;
               phase       = PH_SKIP;
            end else if (hdr_tkl == '0) begin
               phase = PH_OPTION;
            end else begin
               token_left = hdr_tkl;
               phase      = PH_TOKEN;
            end
         end
         PH_TOKEN: begin
            add_item(make_item(KIND_TOKEN, 1'b1, '0, '0, b, ST_ACK));
            token_left = token_left - 4'd1;
            if (token_left == '0) phase = PH_OPTION;
         end
         PH_OPTION: begin
            if (b == PAYLOAD_MARKER) begin
               phase = PH_PAYLOAD;
            end else if (option_count >= MAX_OPTIONS) begin
               phase = PH_SKIP;
            end else if (b[7:4] == NIBBLE_RESERVED || b[3:0] == NIBBLE_RESERVED) begin
               parse_error = ST_OPTION;
               phase       = PH_SKIP;
            end else begin
               value_left = 16'(b[3:0]);
               if (b[7:4] == NIBBLE_EXT_BYTE) begin
                  phase = PH_DELTA13;
               end else if (b[7:4] == NIBBLE_EXT_WORD) begin
                  phase = PH_DELTA14_HI;
               end else begin
                  option_delta = 16'(b[7:4]);
                  finish_delta();
               end
            end
         end
         PH_DELTA13: begin
            option_delta = 16'(b) + EXT_BYTE_BIAS;
            finish_delta();
         end
         PH_DELTA14_HI: begin
            option_delta = 16'(b);
            phase        = PH_DELTA14_LO;
         end
         PH_DELTA14_LO: begin
            option_delta = {option_delta[7:0], b} + EXT_WORD_BIAS;
            finish_delta();
         end
         PH_LEN13: begin
            value_left = 16'(b) + EXT_BYTE_BIAS;
            open_option();
         end
         PH_LEN14_HI: begin
            value_left = 16'(b);
            phase      = PH_LEN14_LO;
         end
         PH_LEN14_LO: begin
            value_left = {value_left[7:0], b} + EXT_WORD_BIAS;
            open_option();
         end
         PH_VALUE: begin
            add_item(make_item(KIND_VALUE, 1'b1, option_number, '0, b, ST_ACK));
            value_left = value_left - 16'd1;
            if (value_left == '0) phase = PH_OPTION;
         end
         PH_PAYLOAD: begin
            add_item(make_item(KIND_PAYLOAD, 1'b1, '0, '0, b, ST_ACK));
         end
         default: begin
         end
      endcase
   endtask

   task automatic close_datagram();
      status_type st;
      if (phase <= PH_TOKEN) begin
         st = ST_SHORT;
      end else if (phase >= PH_DELTA13 && phase <= PH_VALUE) begin
         st = ST_OPTION;
      end else if (parse_error != ST_ACK) begin
         st = parse_error;
      end else begin
         st = (hdr_msg_type == TYPE_ACK) ? ST_ACK : ST_NOT_ACK;
      end
      add_item(make_item(KIND_END, phase >= PH_TOKEN, '0, '0, '0, st));
      clear_parser();
   endtask

   task automatic predict_byte_items(input logic [7:0] b, input logic last_byte);
      byte_items.delete();
      if (byte_count < MAX_PACKET) begin
         byte_count++;
         parse_byte(b);
      end
      if (last_byte) close_datagram();
      if (byte_items.size() > 0) byte_items[byte_items.size() - 1].last_of_run = 1'b1;
      owed_items = {owed_items, byte_items};
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         owed_items.delete();
         mismatch_count = 0;
         pending_items <= 0;
      end else begin
         if (req_valid && req_ready)
            predict_byte_items(req_data.data_byte, req_data.end_of_datagram);
         if (rsp_valid && rsp_ready) begin
            if (owed_items.size() == 0)
               report_mismatch($sformatf("item of kind %0d with nothing owed",
                                         rsp_data.item_kind));
            else
               check_item(rsp_data, owed_items.pop_front());
         end
         pending_items <= owed_items.size();
      end
   end

endmodule

// ===== sim/coap_message_parser_top_test.sv =====
// ----------------------------------------------------------------------------
// CoAP message parser test
// Feeds the parser a short list of hand-picked datagrams, then random ones:
// mostly well-formed headers, tokens and options with random content, plus
// noise, bad fields and truncation. Both channels idle and stall at random
// in several phases. The item check beside the parser predicts and compares
// every item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module coap_message_parser_top_test
   import cmp_pkg::*;
();

   localparam int         PHASE_BYTES     = 100;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int mismatch_count;
   int pending_items;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int idle_by_phase [4] = '{0, 66, 0, 24};
   int stall_by_phase [4] = '{0, 0, 66, 24};

   logic [7:0] frame_bytes [$];

   coap_message_parser_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   coap_message_parser_check parse_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_items  (pending_items)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic add_byte(input logic [7:0] b);
      frame_bytes = {frame_bytes, b};
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last_byte);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, end_of_datagram: last_byte};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // hold off the sender until every owed item has left the parser
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_items != 0) @(posedge clock);
   endtask

   task automatic build_datagram();
      int         tkl;
      int         n_opts;
      int         n_value;
      int         n_bytes;
      int         pick;
      logic [3:0] d_nib;
      logic [3:0] l_nib;
      logic [7:0] ext [$];
      frame_bytes.delete();
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(8, 1)) add_byte(8'($urandom_range(255)));
         return;
      end
      tkl = ($urandom_range(99) < 6) ? $urandom_range(15, 9) : $urandom_range(MAX_TOKEN);
      add_byte({($urandom_range(99) < 8) ? 2'($urandom_range(3)) : COAP_VERSION,
                2'($urandom_range(3)), 4'(tkl)});
      repeat (3) add_byte(8'($urandom_range(255)));
      repeat (tkl) add_byte(8'($urandom_range(255)));
      n_opts = ($urandom_range(99) < 15) ? $urandom_range(MAX_OPTIONS + 3, MAX_OPTIONS)
                                         : $urandom_range(4);
      repeat (n_opts) begin
         ext.delete();
         pick = $urandom_range(9);
         if (pick < 6) begin
            d_nib = 4'($urandom_range(12));
         end else if (pick < 8) begin
            d_nib = NIBBLE_EXT_BYTE;
            ext   = {ext, 8'($urandom_range(255))};
         end else begin
            d_nib = NIBBLE_EXT_WORD;
            ext   = {ext, 8'($urandom_range(255))};
            ext   = {ext, 8'($urandom_range(255))};
         end
         pick = $urandom_range(99);
         if (pick < 70) begin
            l_nib   = 4'($urandom_range(12));
            n_value = l_nib;
         end else if (pick < 85) begin
            l_nib   = NIBBLE_EXT_BYTE;
            n_value = $urandom_range(3);
            ext     = {ext, 8'(n_value)};
            n_value += 13;
         end else begin
            // wrap the decoded length past 65535 down to a short value
            l_nib   = NIBBLE_EXT_WORD;
            n_value = $urandom_range(12);
            ext     = {ext, 8'hFE};
            ext     = {ext, 8'(8'hF3 + n_value)};
         end
         if ($urandom_range(99) < 4) begin
            if ($urandom_range(1)) d_nib = NIBBLE_RESERVED;
            else l_nib = NIBBLE_RESERVED;
         end
         add_byte({d_nib, l_nib});
         foreach (ext[i]) add_byte(ext[i]);
         repeat (n_value) add_byte(8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 60) begin
         add_byte(PAYLOAD_MARKER);
         repeat ($urandom_range(6)) add_byte(8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 10) begin
         n_bytes = $urandom_range(frame_bytes.size(), 1);
         while (frame_bytes.size() > n_bytes) void'(frame_bytes.pop_back());
      end
   endtask

   initial begin
      int phase_bytes;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      frame_bytes = '{8'h40};
      send_frame();
      frame_bytes = '{8'h00, 8'hFF, 8'h12, 8'h34};
      send_frame();
      frame_bytes = '{8'h69, 8'h01, 8'h00, 8'h01};
      send_frame();
      frame_bytes = '{8'h62, 8'h45, 8'hAB, 8'hCD, 8'h77};
      send_frame();
      frame_bytes = '{8'h60, 8'h44, 8'h00, 8'h02, PAYLOAD_MARKER};
      send_frame();
      frame_bytes = '{8'h50, 8'h01, 8'hFF, 8'hFF, 8'hF1};
      send_frame();
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = idle_by_phase[phase];
         recv_stall_pct = stall_by_phase[phase];
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            build_datagram();
            send_frame();
            phase_bytes += frame_bytes.size();
         end
         wait_drained();
      end

      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && pending_items == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
